// ===== sv/ddws_pkg.sv =====
package ddws_pkg;

   localparam int DataW = 32;
   localparam int OpW   = DataW + 1;           // signed operand of the shared multiplier
   localparam int ProdW = 2 * OpW;             // full signed product
   localparam int QBits = 16;                  // Q16.16 fraction bits
   localparam int AccW  = ProdW - QBits;       // floored product and drive accumulator

   localparam logic signed [DataW-1:0] IntegLimit = 32'sd1310720;   // 20.0 in Q16.16

   typedef logic signed [OpW-1:0]   mul_op_type;
   typedef logic signed [ProdW-1:0] mul_prod_type;
   typedef logic signed [AccW-1:0]  acc_type;

   typedef enum logic [2:0] {
      CSR_SPEED_SCALE = 3'd0,
      CSR_LINEAR_GAIN = 3'd1,
      CSR_TURN_GAIN   = 3'd2,
      CSR_PROP_GAIN   = 3'd3,
      CSR_INTEG_GAIN  = 3'd4,
      CSR_DERIV_GAIN  = 3'd5,
      CSR_TIME_STEP   = 3'd6,
      CSR_DEAD_BAND   = 3'd7
   } csr_index_type;

   // Clamp a wide signed value to the 32-bit signed range.
   function automatic logic signed [DataW-1:0] sat32(input mul_prod_type x);
      logic [ProdW-DataW:0] hi;
      hi = x[ProdW-1:DataW-1];
      if ((&hi) || !(|hi)) begin
         return x[DataW-1:0];
      end
      return x[ProdW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
   endfunction

   function automatic mul_prod_type acc_ext(input acc_type x);
      return {{(ProdW-AccW){x[AccW-1]}}, x};
   endfunction

endpackage

// ===== sv/ddws_mul.sv =====
module ddws_mul (
   input  logic                  clock,
   input  ddws_pkg::mul_op_type  op_a,
   input  ddws_pkg::mul_op_type  op_b,
   output ddws_pkg::mul_prod_type prod
);
   import ddws_pkg::*;

   mul_prod_type prod_ff;
   mul_prod_type prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== sv/diff_drive_wheel_speed_pid.sv =====
// Each request runs the right wheel, then the left, through S_DELTA to S_WRITE, then S_TLIN to S_OUT.
// req_ready is high only while the sequencer is idle, so a new request waits until the last one leaves S_OUT.
// Every product goes through one shared registered 33x33 multiplier, one product per cycle.
// Reset (synchronous, active high) zeroes wheel state, loads default gains, drops rsp_valid.
// A finished response waits in its own register; the next one is held until it is taken.
module diff_drive_wheel_speed_pid (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [31:0]          req_count_right,
   input  logic signed [31:0]          req_count_left,
   input  logic signed [31:0]          req_command_linear,
   input  logic signed [31:0]          req_command_angular,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [31:0]          rsp_drive_right,
   output logic signed [31:0]          rsp_drive_left,
   input  logic                        csr_we,
   input  ddws_pkg::csr_index_type     csr_index,
   input  logic [31:0]                 csr_wdata
);
   import ddws_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DELTA,     // form count delta
      S_SMUL,      // issue delta * speed_scale
      S_SPEED,     // saturate measured speed
      S_ERR,       // error against target
      S_IMUL,      // issue time_step * error, form derivative
      S_PMUL,      // issue prop_gain * error, update integral
      S_DMUL,      // issue deriv_gain * derivative, start drive sum
      S_GMUL,      // issue integ_gain * integral
      S_ACC,       // last term of drive sum
      S_WRITE,     // commit wheel state
      S_TLIN,      // issue linear_gain * command_linear
      S_TTURN,     // issue turn_gain * command_angular
      S_TGT,       // new wheel targets
      S_OUT        // load response register
   } state_type;

   // Configuration
   logic [30:0]        speed_scale_ff, linear_gain_ff, turn_gain_ff, time_step_ff, dead_band_ff;
   logic signed [31:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff;

   // Per-wheel state, index 0 right, 1 left
   logic [31:0]        last_count_ff [2];
   logic signed [31:0] error_integral_ff [2];
   logic signed [31:0] last_error_ff [2];
   logic signed [31:0] wheel_target_ff [2];
   logic signed [31:0] drive_level_ff [2];

   // Captured request
   logic [31:0]        count_r_ff, count_l_ff;
   logic signed [31:0] cmd_lin_ff, cmd_ang_ff;

   // Working registers
   state_type          state_ff, state_in;
   logic               wheel_ff;
   logic signed [31:0] delta_ff, speed_ff, err_ff, deriv_ff, integ_ff;
   acc_type            acc_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_right_ff, rsp_left_ff;

   // Shared multiplier
   mul_op_type         op_a, op_b;
   mul_prod_type       prod;
   acc_type            prod_q;

   logic [31:0]        count_sel;
   logic signed [31:0] delta_in, speed_in, err_in, deriv_in, integ_in, integ_clamped;
   logic signed [31:0] target_r_in, target_l_in;
   logic [32:0]        err_mag;
   logic               outside_band;
   logic               out_free;

   ddws_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // Floor of a Q16.16 product: drop the fraction bits of the signed result.
   assign prod_q = prod[ProdW-1:QBits];

   assign count_sel = wheel_ff ? count_l_ff : count_r_ff;

   assign delta_in = count_sel - last_count_ff[wheel_ff];
   assign speed_in = sat32(prod);
   assign err_in   = sat32(acc_ext(acc_type'(wheel_target_ff[wheel_ff]) - acc_type'(speed_ff)));
   assign deriv_in = sat32(acc_ext(acc_type'(err_ff) - acc_type'(last_error_ff[wheel_ff])));
   assign integ_in = sat32(acc_ext(acc_type'(error_integral_ff[wheel_ff]) + prod_q));

   // Clamp the integral to +-20 after it has fed the drive sum.
   always_comb begin
      if (integ_ff > IntegLimit) begin
         integ_clamped = IntegLimit;
      end else if (integ_ff < -IntegLimit) begin
         integ_clamped = -IntegLimit;
      end else begin
         integ_clamped = integ_ff;
      end
   end

   // Dead band: an error exactly at the band edge leaves the drive alone.
   assign err_mag      = err_ff[31] ? 33'(-{err_ff[31], err_ff}) : 33'({err_ff[31], err_ff});
   assign outside_band = err_mag > {2'b00, dead_band_ff};

   // Inverse kinematics: right = a - b, left = a + b.
   assign target_r_in = sat32(acc_ext(acc_ff - prod_q));
   assign target_l_in = sat32(acc_ext(acc_ff + prod_q));

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Select multiplier operands for the step being issued.
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         S_SMUL: begin
            op_a = mul_op_type'(delta_ff);
            op_b = mul_op_type'({2'b00, speed_scale_ff});
         end
         S_IMUL: begin
            op_a = mul_op_type'({2'b00, time_step_ff});
            op_b = mul_op_type'(err_ff);
         end
         S_PMUL: begin
            op_a = mul_op_type'(prop_gain_ff);
            op_b = mul_op_type'(err_ff);
         end
         S_DMUL: begin
            op_a = mul_op_type'(deriv_gain_ff);
            op_b = mul_op_type'(deriv_ff);
         end
         S_GMUL: begin
            op_a = mul_op_type'(integ_gain_ff);
            op_b = mul_op_type'(integ_ff);
         end
         S_TLIN: begin
            op_a = mul_op_type'({2'b00, linear_gain_ff});
            op_b = mul_op_type'(cmd_lin_ff);
         end
         S_TTURN: begin
            op_a = mul_op_type'({2'b00, turn_gain_ff});
            op_b = mul_op_type'(cmd_ang_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_DELTA;
         S_DELTA: state_in = S_SMUL;
         S_SMUL:  state_in = S_SPEED;
         S_SPEED: state_in = S_ERR;
         S_ERR:   state_in = S_IMUL;
         S_IMUL:  state_in = S_PMUL;
         S_PMUL:  state_in = S_DMUL;
         S_DMUL:  state_in = S_GMUL;
         S_GMUL:  state_in = S_ACC;
         S_ACC:   state_in = S_WRITE;
         S_WRITE: state_in = wheel_ff ? S_TLIN : S_DELTA;
         S_TLIN:  state_in = S_TTURN;
         S_TTURN: state_in = S_TGT;
         S_TGT:   state_in = S_OUT;
         S_OUT:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         wheel_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         speed_scale_ff  <= 31'd328;
         linear_gain_ff  <= 31'd347855;
         turn_gain_ff    <= 31'd48701;
         prop_gain_ff    <= 32'sd196608;
         integ_gain_ff   <= 32'sd66;
         deriv_gain_ff   <= 32'sd0;
         time_step_ff    <= 31'd655;
         dead_band_ff    <= 31'd655;
         for (int w = 0; w < 2; w++) begin
            last_count_ff[w]     <= '0;
            error_integral_ff[w] <= '0;
            last_error_ff[w]     <= '0;
            wheel_target_ff[w]   <= '0;
            drive_level_ff[w]    <= '0;
         end
      end else begin
         state_ff <= state_in;

         // The user must write configuration only while idle; the block itself does not enforce this.
         if (csr_we) begin
            unique case (csr_index)
               CSR_SPEED_SCALE: speed_scale_ff <= csr_wdata[30:0];
               CSR_LINEAR_GAIN: linear_gain_ff <= csr_wdata[30:0];
               CSR_TURN_GAIN:   turn_gain_ff   <= csr_wdata[30:0];
               CSR_PROP_GAIN:   prop_gain_ff   <= csr_wdata;
               CSR_INTEG_GAIN:  integ_gain_ff  <= csr_wdata;
               CSR_DERIV_GAIN:  deriv_gain_ff  <= csr_wdata;
               CSR_TIME_STEP:   time_step_ff   <= csr_wdata[30:0];
               CSR_DEAD_BAND:   dead_band_ff   <= csr_wdata[30:0];
               default: ;
            endcase
         end

         // Drop the response once taken, unless a new one loads in the same cycle.
         if (rsp_valid_ff && rsp_ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_WRITE: begin
               if (outside_band) begin
                  drive_level_ff[wheel_ff] <= sat32(acc_ext(acc_ff));
               end
               error_integral_ff[wheel_ff] <= integ_clamped;
               last_error_ff[wheel_ff]     <= err_ff;
               last_count_ff[wheel_ff]     <= count_sel;
               wheel_ff                    <= ~wheel_ff;
            end
            S_TGT: begin
               wheel_target_ff[0] <= target_r_in;
               wheel_target_ff[1] <= target_l_in;
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_right_ff <= drive_level_ff[0];
                  rsp_left_ff  <= drive_level_ff[1];
               end
            end
            default: ;
         endcase
      end

      // Datapath registers, no reset
      if (state_ff == S_IDLE && req_valid) begin
         count_r_ff <= req_count_right;
         count_l_ff <= req_count_left;
         cmd_lin_ff <= req_command_linear;
         cmd_ang_ff <= req_command_angular;
      end
      case (state_ff)
         S_DELTA: delta_ff <= delta_in;
         S_SPEED: speed_ff <= speed_in;
         S_ERR:   err_ff   <= err_in;
         S_IMUL:  deriv_ff <= deriv_in;
         S_PMUL:  integ_ff <= integ_in;
         S_DMUL:  acc_ff   <= acc_type'(drive_level_ff[wheel_ff]) + prod_q;
         S_GMUL:  acc_ff   <= acc_ff + prod_q;
         S_ACC:   acc_ff   <= acc_ff + prod_q;
         S_TTURN: acc_ff   <= prod_q;
         default: ;
      endcase
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_right = rsp_right_ff;
   assign rsp_drive_left  = rsp_left_ff;

   // A request starts at the right wheel and both wheels are done before targets move.
   a_start_right: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !wheel_ff)
      else $error("request accepted with left wheel selected");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sequencer idle right after accepting a request");

   a_integ_right: assert property (@(posedge clock) disable iff (reset)
      (error_integral_ff[0] <= IntegLimit) && (error_integral_ff[0] >= -IntegLimit))
      else $error("right integral outside clamp");

   a_integ_left: assert property (@(posedge clock) disable iff (reset)
      (error_integral_ff[1] <= IntegLimit) && (error_integral_ff[1] >= -IntegLimit))
      else $error("left integral outside clamp");

   a_tgt_after_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TLIN) |-> ($past(state_ff) == S_WRITE) && !wheel_ff)
      else $error("targets started before both wheels were done");

endmodule

// ===== test/tb_diff_drive_wheel_speed_pid.sv =====
module tb_diff_drive_wheel_speed_pid;
   timeunit 1ns;
   timeprecision 1ps;

   import ddws_pkg::*;

   // Q16.16 saturation limits and the +-20.0 clamp on the stored integral
   localparam longint SatHi      = 64'sd2147483647;
   localparam longint SatLo      = -64'sd2147483648;
   localparam longint IntegClamp = 64'sd1310720;

   localparam int MaxWait       = 17;
   localparam int DrainCycles   = 30;   // a margin beyond the latency from request accept to response
   localparam int HoldOffCycles = 400;
   localparam int MaxReports    = 10;

   typedef struct packed {
      logic signed [31:0] right;
      logic signed [31:0] left;
   } drive_pair_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [31:0]   req_count_right;
   logic signed [31:0]   req_count_left;
   logic signed [31:0]   req_command_linear;
   logic signed [31:0]   req_command_angular;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic signed [31:0]   rsp_drive_right;
   logic signed [31:0]   rsp_drive_left;
   logic                 csr_we;
   csr_index_type        csr_index;
   logic [31:0]          csr_wdata;

   // Drive values still owed by the block, oldest first
   drive_pair_type drive_expect_q[$];

   // Shadow of the gain registers, already masked or sign-extended to their width
   longint      gain_shadow [8];
   logic [31:0] csr_plan [8];

   // Per-wheel controller state, index 0 right, 1 left
   logic [31:0] enc_seen [2];
   int          integ_acc [2];
   int          err_prev [2];
   int          speed_goal [2];
   int          drive_acc [2];

   // Running encoder positions for well-formed random traffic
   logic [31:0] enc_right = '0;
   logic [31:0] enc_left  = '0;

   bit no_idle      = 1'b0;
   int hold_request = 0;
   int fail_count   = 0;

   diff_drive_wheel_speed_pid dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_count_right     (req_count_right),
      .req_count_left      (req_count_left),
      .req_command_linear  (req_command_linear),
      .req_command_angular (req_command_angular),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_drive_right     (rsp_drive_right),
      .rsp_drive_left      (rsp_drive_left),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic int clamp32(input longint x);
      if (x > SatHi) return int'(SatHi);
      if (x < SatLo) return int'(SatLo);
      return int'(x);
   endfunction

   function automatic void reset_wheel_model();
      for (int w = 0; w < 2; w++) begin
         enc_seen[w]   = '0;
         integ_acc[w]  = 0;
         err_prev[w]   = 0;
         speed_goal[w] = 0;
         drive_acc[w]  = 0;
      end
      gain_shadow[CSR_SPEED_SCALE] = 328;
      gain_shadow[CSR_LINEAR_GAIN] = 347855;
      gain_shadow[CSR_TURN_GAIN]   = 48701;
      gain_shadow[CSR_PROP_GAIN]   = 196608;
      gain_shadow[CSR_INTEG_GAIN]  = 66;
      gain_shadow[CSR_DERIV_GAIN]  = 0;
      gain_shadow[CSR_TIME_STEP]   = 655;
      gain_shadow[CSR_DEAD_BAND]   = 655;
   endfunction

   // The PID gains are signed 32 bit; the rest keep 31 bits and drop the top one.
   function automatic void shadow_csr(input csr_index_type idx, input logic [31:0] data);
      case (idx)
         CSR_PROP_GAIN, CSR_INTEG_GAIN, CSR_DERIV_GAIN: begin
            gain_shadow[idx] = longint'(signed'(data));
         end
         default: begin
            gain_shadow[idx] = longint'({1'b0, data[30:0]});
         end
      endcase
   endfunction

   // One wheel of one tick. Products are exact in 64 bits; >>> 16 floors them.
   function automatic int wheel_drive(input int w, input logic [31:0] cnt);
      logic [31:0] diff;
      int          spd;
      int          err;
      int          integ;
      int          deriv;
      longint      mag;
      longint      pid_sum;
      diff  = cnt - enc_seen[w];
      spd   = clamp32(longint'(signed'(diff)) * gain_shadow[CSR_SPEED_SCALE]);
      err   = clamp32(longint'(speed_goal[w]) - longint'(spd));
      integ = clamp32(longint'(integ_acc[w])
                      + ((gain_shadow[CSR_TIME_STEP] * longint'(err)) >>> 16));
      deriv = clamp32(longint'(err) - longint'(err_prev[w]));
      mag   = (err < 0) ? -longint'(err) : longint'(err);
      // an error exactly on the dead band edge leaves the drive alone
      if (mag > gain_shadow[CSR_DEAD_BAND]) begin
         pid_sum = ((gain_shadow[CSR_PROP_GAIN]  * longint'(err))   >>> 16)
                 + ((gain_shadow[CSR_DERIV_GAIN] * longint'(deriv)) >>> 16)
                 + ((gain_shadow[CSR_INTEG_GAIN] * longint'(integ)) >>> 16);
         drive_acc[w] = clamp32(longint'(drive_acc[w]) + pid_sum);
      end
      // clamp the integral only after it has been used
      if (integ > IntegClamp) integ = int'(IntegClamp);
      if (integ < -IntegClamp) integ = int'(-IntegClamp);
      integ_acc[w] = integ;
      err_prev[w]  = err;
      enc_seen[w]  = cnt;
      return drive_acc[w];
   endfunction

   // Whole tick: both wheels on the current targets, then new targets from the command.
   function automatic drive_pair_type predict_drive(input logic [31:0] cr,
                                                    input logic [31:0] cl,
                                                    input logic [31:0] cv,
                                                    input logic [31:0] ca);
      drive_pair_type result;
      longint         fwd;
      longint         spin;
      result.right  = wheel_drive(0, cr);
      result.left   = wheel_drive(1, cl);
      fwd           = (gain_shadow[CSR_LINEAR_GAIN] * longint'(signed'(cv))) >>> 16;
      spin          = (gain_shadow[CSR_TURN_GAIN] * longint'(signed'(ca))) >>> 16;
      speed_goal[0] = clamp32(fwd - spin);
      speed_goal[1] = clamp32(fwd + spin);
      return result;
   endfunction

   // ---------------------------------------------------------------- shared tasks

   // Idle cycles for one request or one response; zero in burst stretches.
   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, MaxWait);
   endfunction

   task automatic log_failure(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (fail_count < MaxReports) begin
         $display("%0t ns: %s: expected %0d, got %0d", $time, what,
                  signed'(want), signed'(got));
      end
      fail_count++;
   endtask

   // Offer one request and hold it until accepted. Valid stays high across back-to-back
   // requests; it is dropped only when an idle gap comes first.
   task automatic send_request(input logic [31:0] cr, input logic [31:0] cl,
                               input logic [31:0] cv, input logic [31:0] ca);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_count_right     <= cr;
      req_count_left      <= cl;
      req_command_linear  <= cv;
      req_command_angular <= ca;
      do @(posedge clock); while (!req_ready);
      drive_expect_q.push_back(predict_drive(cr, cl, cv, ca));
   endtask

   // Drop valid and wait until the block has delivered everything it owes.
   task automatic settle();
      req_valid <= 1'b0;
      while (drive_expect_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Write all eight registers from csr_plan; only call with the block idle.
   task automatic apply_csr_plan();
      settle();
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= csr_plan[i];
         @(posedge clock);
         shadow_csr(csr_index_type'(i), csr_plan[i]);
      end
      csr_we <= 1'b0;
   endtask

   // Gains in a range where the loop does something visible; the top bit of the
   // unsigned registers is random noise that the block must ignore.
   task automatic draw_moderate_plan();
      logic [31:0] top;
      top = $urandom & 32'h8000_0000;
      csr_plan[CSR_SPEED_SCALE] = $urandom_range(0, 2000) | top;
      top = $urandom & 32'h8000_0000;
      csr_plan[CSR_LINEAR_GAIN] = $urandom_range(0, 32'h8_0000) | top;
      top = $urandom & 32'h8000_0000;
      csr_plan[CSR_TURN_GAIN]   = $urandom_range(0, 32'h8_0000) | top;
      csr_plan[CSR_PROP_GAIN]   = $urandom_range(0, 32'h10_0000) - 32'h8_0000;
      csr_plan[CSR_INTEG_GAIN]  = $urandom_range(0, 32'h2000) - 32'h1000;
      csr_plan[CSR_DERIV_GAIN]  = $urandom_range(0, 32'h4_0000) - 32'h2_0000;
      top = $urandom & 32'h8000_0000;
      csr_plan[CSR_TIME_STEP]   = $urandom_range(0, 32'h1_0000) | top;
      top = $urandom & 32'h8000_0000;
      csr_plan[CSR_DEAD_BAND]   = ($urandom_range(0, 3) == 0) ? top
                                  : ($urandom_range(0, 32'h4000) | top);
   endtask

   // Mostly encoders that creep forward or back and modest commands; now and then
   // (or always, when wide) jump to arbitrary 32-bit values.
   task automatic run_random_items(input int n, input bit wide);
      logic [31:0] cv;
      logic [31:0] ca;
      repeat (n) begin
         if (wide || $urandom_range(0, 9) == 0) begin
            enc_right = $urandom;
            enc_left  = $urandom;
         end else begin
            enc_right = enc_right + $urandom_range(0, 600) - 32'd300;
            enc_left  = enc_left + $urandom_range(0, 600) - 32'd300;
         end
         if (wide || $urandom_range(0, 3) == 0) begin
            cv = $urandom;
            ca = $urandom;
         end else begin
            cv = $urandom_range(0, 32'h4_0000) - 32'h2_0000;
            ca = $urandom_range(0, 32'h4_0000) - 32'h2_0000;
         end
         send_request(enc_right, enc_left, cv, ca);
      end
   endtask

   // ---------------------------------------------------------------- tests

   // Reset gains: zero tick, small motion, counts at the extremes and a wrap.
   task automatic test_reset_defaults();
      send_request(32'd0, 32'd0, 32'd0, 32'd0);
      send_request(32'd100, -32'sd100, 32'd65536, 32'd32768);
      send_request(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_request(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_request(32'hffff_ffff, 32'd0, 32'd0, 32'd0);
   endtask

   // Speed scale zero and unit linear gain make the next error equal the command,
   // so walk the error onto the dead band edge from both sides, then one past it.
   task automatic test_dead_band_edge();
      csr_plan = '{32'd0, 32'd65536, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd655, 32'd1000};
      apply_csr_plan();
      send_request($urandom, $urandom, 32'd1000, 32'h7fff_ffff);
      send_request($urandom, $urandom, -32'sd1000, 32'h8000_0000);
      send_request($urandom, $urandom, 32'd1001, 32'h7fff_ffff);
      send_request($urandom, $urandom, -32'sd1001, 32'h8000_0000);
      send_request($urandom, $urandom, 32'd0, 32'd0);
   endtask

   // Push every product and sum to both 32-bit limits, pin the integral at the clamp,
   // then set the widest dead band so the drive must hold.
   task automatic test_saturation();
      csr_plan = '{32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'h0};
      apply_csr_plan();
      send_request(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      send_request(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
      send_request(32'd0, 32'd0, 32'h7fff_ffff, 32'h8000_0000);
      send_request(32'd1, 32'hffff_ffff, 32'd0, 32'd0);

      csr_plan = '{32'h0000_0001, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0};
      apply_csr_plan();
      send_request(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_request(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_request(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_request(32'd0, 32'd0, 32'h8000_0000, 32'h8000_0000);

      csr_plan[CSR_DEAD_BAND] = 32'h7fff_ffff;
      apply_csr_plan();
      send_request(32'h4000_0000, 32'hc000_0000, 32'h7fff_ffff, 32'h0);
      send_request(32'd0, 32'd0, 32'd0, 32'd0);
   endtask

   // Power-on gains with realistic traffic and random idling on both sides.
   task automatic test_closed_loop();
      csr_plan = '{32'd328, 32'd347855, 32'd48701, 32'd196608,
                   32'd66, 32'd0, 32'd655, 32'd655};
      apply_csr_plan();
      run_random_items(400, 1'b0);
   endtask

   task automatic test_random_gains(input int n, input bit burst);
      draw_moderate_plan();
      apply_csr_plan();
      no_idle = burst;
      run_random_items(n, 1'b0);
      no_idle = 1'b0;
   endtask

   // Arbitrary register words and arbitrary request fields.
   task automatic test_full_range();
      for (int i = 0; i < 8; i++) csr_plan[i] = $urandom;
      apply_csr_plan();
      run_random_items(350, 1'b1);
   endtask

   // Starve the response side for a long stretch while requests keep coming, so the
   // held response and the busy sequencer back up into req_ready.
   task automatic test_backpressure();
      draw_moderate_plan();
      apply_csr_plan();
      no_idle      = 1'b1;
      hold_request = HoldOffCycles;
      run_random_items(80, 1'b0);
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------- response side

   // Sample at the edge, check each accepted response against the oldest pending one,
   // then decide rsp_ready for the next edge.
   initial begin : response_monitor
      drive_pair_type want;
      int             stall_left;
      int             hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (drive_expect_q.size() == 0) begin
               log_failure("response with no request pending", 32'd0, rsp_drive_right);
            end else begin
               want = drive_expect_q.pop_front();
               if (rsp_drive_right !== want.right) begin
                  log_failure("drive_right mismatch", want.right, rsp_drive_right);
               end
               if (rsp_drive_left !== want.left) begin
                  log_failure("drive_left mismatch", want.left, rsp_drive_left);
               end
            end
            stall_left = draw_wait();
         end
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_count_right     <= '0;
      req_count_left      <= '0;
      req_command_linear  <= '0;
      req_command_angular <= '0;
      csr_we              <= 1'b0;
      csr_index           <= CSR_SPEED_SCALE;
      csr_wdata           <= '0;
      reset_wheel_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_dead_band_edge();
      test_saturation();
      test_closed_loop();
      test_random_gains(400, 1'b0);
      test_random_gains(400, 1'b1);
      test_full_range();
      test_backpressure();
      test_random_gains(200, 1'b0);
      settle();

      if (fail_count == 0) begin
         $display("diff_drive_wheel_speed_pid regression: pass");
      end else begin
         $display("diff_drive_wheel_speed_pid regression: fail");
      end
      $finish;
   end

   // Hang guard, roughly ten times the slowest legal run.
   initial begin
      #5_000_000;
      $display("diff_drive_wheel_speed_pid regression: fail");
      $finish;
   end

endmodule
